// ----- rtl/nmt_pkg.sv -----
package nmt_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP_IN  = 2'd0,
    KIND_LOOKUP_OUT = 2'd1,
    KIND_INSERT     = 2'd2,
    KIND_TICK       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ICMP_TO = 2'd0,
    REG_EST_TO  = 2'd1,
    REG_TRA_TO  = 2'd2,
    REG_MIN_PORT = 2'd3
  } reg_idx_t;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TICK_DONE = 3'd4;

  localparam logic [1:0] PH_OPEN  = 2'd0;
  localparam logic [1:0] PH_EST   = 2'd1;
  localparam logic [1:0] PH_CLOSE = 2'd2;
  localparam logic [1:0] PH_TEAR  = 2'd3;

  localparam int FL_RACK = 0;
  localparam int FL_SACK = 1;
  localparam int FL_SFIN = 2;
  localparam int FL_RFIN = 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MSCAN,
    S_MDONE,
    S_CSCAN,
    S_CUPD,
    S_MWR,
    S_TC_RD,
    S_TC_MAP,
    S_TC_DEC,
    S_TM_RD,
    S_TM_DEC
  } state_t;

  typedef struct packed {
    logic        proto;
    logic [31:0] inner_ip;
    logic [31:0] outer_ip;
    logic [15:0] inner_port;
    logic [15:0] outer_port;
    logic [31:0] last_used;
    logic [31:0] stamp;
  } map_ent_t;

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [1:0]  phase;
    logic [3:0]  marks;
    logic [31:0] in_fin_seq;
    logic [31:0] out_fin_seq;
  } conn_data_t;

endpackage

// ----- rtl/nmt_ram.sv -----
module nmt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/nat_mapping_table_with_tcp_tracking_core.sv -----
// NAT translation table with TCP connection tracking.
// A request is taken when start is high and busy is low; kind selects an
// internal lookup, an external lookup, an insert or a one-second tick.
// Exactly one result per request appears on the out_ ports for one cycle,
// marked by out_valid; the receiver cannot stall, so it must take it then.
// Mappings and connections live in two single-port-read RAMs; lookups and
// inserts walk them one entry per cycle.
// Lookup or insert: a walk of the mappings (an insert stops at the first free
// entry), for TCP a walk of the connections up to the first match and the
// connection update, then the mapping write-back (skipped on a miss).
// Tick: a live connection is freed if its mapping is gone or it timed out; then
// a live mapping is freed on ICMP timeout or, for TCP, with no live connection.
// One request at a time: busy stays high until its result is shown.
// cfg_we writes a timeout or the port base at once; write only while idle.
// Reset (rst_n low at a clock edge) clears all valid bits, the clock, the
// insert counter, the id/port allocators and the registers to defaults.
// RAM contents are not cleared; an entry is read only once marked valid.
module nat_mapping_table_with_tcp_tracking_core #(
  parameter int MAP_ENTRIES  = 64,
  parameter int CONN_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic        in_proto,
  input  logic [31:0] in_inner_ip,
  input  logic [15:0] in_inner_port,
  input  logic [15:0] in_outer_port,
  input  logic [31:0] in_outer_ip,
  input  logic [31:0] in_dest_ip,
  input  logic [15:0] in_dest_port,
  input  logic [3:0]  in_segment_flags,
  input  logic [31:0] in_seq_number,
  input  logic [31:0] in_ack_number,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_inner_ip,
  output logic [31:0] out_found_outer_ip,
  output logic [15:0] out_found_inner_port,
  output logic [15:0] out_found_outer_port,
  output logic [1:0]  out_conn_state,
  output logic        out_conn_dropped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MW  = $clog2(MAP_ENTRIES);
  localparam int CW  = $clog2(CONN_ENTRIES);
  localparam int SW  = ((MW > CW) ? MW : CW) + 1;
  localparam int MDW = $bits(nmt_pkg::map_ent_t);
  localparam int CDW = $bits(nmt_pkg::conn_data_t);

  nmt_pkg::state_t state_r, state_nxt;

  nmt_pkg::kind_t kind_r, kind_nxt;
  logic        proto_r, proto_nxt;
  logic [31:0] iip_r, iip_nxt, oip_r, oip_nxt, dip_r, dip_nxt;
  logic [15:0] iport_r, iport_nxt, oport_r, oport_nxt, dport_r, dport_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [31:0] seq_r, seq_nxt, ack_r, ack_nxt;

  logic [15:0] icmp_to_r, icmp_to_nxt, est_to_r, est_to_nxt;
  logic [15:0] tra_to_r, tra_to_nxt, minp_r, minp_nxt;
  logic [15:0] next_tcp_r, next_tcp_nxt, next_icmp_r, next_icmp_nxt;
  logic [31:0] now_r, now_nxt, icnt_r, icnt_nxt;

  logic [MAP_ENTRIES-1:0]  map_vld_r, map_vld_nxt, has_conn_r, has_conn_nxt;
  logic [CONN_ENTRIES-1:0] conn_vld_r, conn_vld_nxt;

  logic [SW-1:0] rd_cnt_r, rd_cnt_nxt, pidx_r, pidx_nxt, t_idx_r, t_idx_nxt;
  logic          pv_r, pv_nxt;
  logic          found_r, found_nxt;
  logic [MW-1:0] m_r, m_nxt, towner_r, towner_nxt;
  logic [31:0]   best_r, best_nxt;
  nmt_pkg::map_ent_t   ment_r, ment_nxt;
  logic          cfound_r, cfound_nxt, cfree_vld_r, cfree_vld_nxt;
  logic [CW-1:0] c_r, c_nxt, cfree_r, cfree_nxt;
  nmt_pkg::conn_data_t cent_r, cent_nxt;
  logic [1:0]    tphase_r, tphase_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [31:0] oiip_r, oiip_nxt, ooip_r, ooip_nxt;
  logic [15:0] oiport_r, oiport_nxt, ooport_r, ooport_nxt;
  logic [1:0]  ocs_r, ocs_nxt;
  logic        odrop_r, odrop_nxt;

  logic                map_we;
  logic [MW-1:0]       map_waddr, map_raddr;
  logic [MDW-1:0]      map_wdata, map_rdata_raw;
  nmt_pkg::map_ent_t   map_rd;
  logic                conn_we;
  logic [CW-1:0]       conn_waddr, conn_raddr;
  logic [MW+CDW-1:0]   conn_wdata, conn_rdata_raw;
  nmt_pkg::conn_data_t conn_rd;
  logic [MW-1:0]       conn_rd_owner;

  nmt_ram #(.W(MDW), .D(MAP_ENTRIES)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata_raw)
  );

  nmt_ram #(.W(MW + CDW), .D(CONN_ENTRIES)) u_conn_ram (
    .clk(clk), .we(conn_we), .waddr(conn_waddr), .wdata(conn_wdata),
    .raddr(conn_raddr), .rdata(conn_rdata_raw)
  );

  assign map_rd        = nmt_pkg::map_ent_t'(map_rdata_raw);
  assign conn_rd       = nmt_pkg::conn_data_t'(conn_rdata_raw[CDW-1:0]);
  assign conn_rd_owner = conn_rdata_raw[MW+CDW-1:CDW];

  function automatic nmt_pkg::conn_data_t track(
    input nmt_pkg::conn_data_t b,
    input logic [3:0]          fl,
    input logic [31:0]         seq,
    input logic [31:0]         ack
  );
    nmt_pkg::conn_data_t r;
    logic [3:0] mk;
    logic [1:0] ph;
    r  = b;
    mk = b.marks;
    ph = b.phase;
    unique case (ph)
      nmt_pkg::PH_OPEN: begin
        if (fl[nmt_pkg::FL_RACK] &&
            (!mk[nmt_pkg::FL_SFIN] || ack == r.out_fin_seq + 32'd1)) begin
          mk[nmt_pkg::FL_RACK] = 1'b1;
        end
        if (fl[nmt_pkg::FL_SACK]) mk[nmt_pkg::FL_SACK] = 1'b1;
        if (fl[nmt_pkg::FL_SFIN]) begin
          mk[nmt_pkg::FL_SFIN] = 1'b1;
          r.out_fin_seq = seq;
          mk[nmt_pkg::FL_RACK] = 1'b0;
        end
        if (fl[nmt_pkg::FL_RFIN]) begin
          mk[nmt_pkg::FL_RFIN] = 1'b1;
          r.in_fin_seq = seq;
          mk[nmt_pkg::FL_SACK] = 1'b0;
        end
        if (mk[nmt_pkg::FL_RACK] && mk[nmt_pkg::FL_SACK]) begin
          ph = nmt_pkg::PH_EST;
          mk[nmt_pkg::FL_RACK] = 1'b0;
          mk[nmt_pkg::FL_SACK] = 1'b0;
        end
        if (mk[nmt_pkg::FL_SFIN] && mk[nmt_pkg::FL_RFIN]) ph = nmt_pkg::PH_CLOSE;
      end
      nmt_pkg::PH_EST: begin
        if (fl[nmt_pkg::FL_RFIN]) begin
          mk[nmt_pkg::FL_RFIN] = 1'b1;
          r.in_fin_seq = seq;
        end
        if (fl[nmt_pkg::FL_SFIN]) begin
          mk[nmt_pkg::FL_SFIN] = 1'b1;
          r.out_fin_seq = seq;
        end
        if (fl[nmt_pkg::FL_RACK] && mk[nmt_pkg::FL_SFIN] &&
            ack == r.out_fin_seq + 32'd1) begin
          mk[nmt_pkg::FL_RACK] = 1'b1;
        end
        if (fl[nmt_pkg::FL_SACK] && mk[nmt_pkg::FL_RFIN] &&
            ack == r.in_fin_seq + 32'd1) begin
          mk[nmt_pkg::FL_SACK] = 1'b1;
        end
        if (mk[nmt_pkg::FL_SFIN] && mk[nmt_pkg::FL_RFIN]) ph = nmt_pkg::PH_CLOSE;
      end
      nmt_pkg::PH_CLOSE: begin
        if (fl[nmt_pkg::FL_RACK] && ack == r.out_fin_seq + 32'd1) begin
          mk[nmt_pkg::FL_RACK] = 1'b1;
        end
        if (fl[nmt_pkg::FL_SACK] && ack == r.in_fin_seq + 32'd1) begin
          mk[nmt_pkg::FL_SACK] = 1'b1;
        end
        if (mk[nmt_pkg::FL_RACK] && mk[nmt_pkg::FL_SACK]) ph = nmt_pkg::PH_TEAR;
      end
      default: begin
      end
    endcase
    r.marks = mk;
    r.phase = ph;
    return r;
  endfunction

  // scan helpers
  logic [MW-1:0] mp_idx, t_midx;
  logic [CW-1:0] cp_idx, t_cidx;
  logic          mscan_last, cscan_last, ins_free, lk_hit, lk_better, c_match;
  logic          tc_end, tm_end, tc_exp, tm_exp;
  logic [31:0]   lk_diff, elapsed;
  logic [15:0]   tc_lim;

  always_comb begin
    mp_idx     = pidx_r[MW-1:0];
    cp_idx     = pidx_r[CW-1:0];
    t_midx     = t_idx_r[MW-1:0];
    t_cidx     = t_idx_r[CW-1:0];
    mscan_last = pv_r && (pidx_r == SW'(MAP_ENTRIES - 1));
    cscan_last = pv_r && (pidx_r == SW'(CONN_ENTRIES - 1));
    ins_free   = pv_r && (kind_r == nmt_pkg::KIND_INSERT) && !map_vld_r[mp_idx];
    lk_hit     = pv_r && (kind_r != nmt_pkg::KIND_INSERT) && map_vld_r[mp_idx] &&
                 (map_rd.proto == proto_r) &&
                 ((kind_r == nmt_pkg::KIND_LOOKUP_IN) ?
                  (map_rd.inner_ip == iip_r && map_rd.inner_port == iport_r) :
                  (map_rd.outer_port == oport_r));
    lk_diff    = icnt_r - map_rd.stamp;
    lk_better  = !found_r || (lk_diff < best_r);
    c_match    = pv_r && conn_vld_r[cp_idx] && (conn_rd_owner == m_r) &&
                 (conn_rd.dest_ip == dip_r) && (conn_rd.dest_port == dport_r);
    tc_end     = (t_idx_r == SW'(CONN_ENTRIES));
    tm_end     = (t_idx_r == SW'(MAP_ENTRIES));
    elapsed    = now_r - map_rd.last_used;
    unique case (tphase_r)
      nmt_pkg::PH_OPEN, nmt_pkg::PH_CLOSE: tc_lim = tra_to_r;
      nmt_pkg::PH_EST:                     tc_lim = est_to_r;
      default:                             tc_lim = 16'd0;
    endcase
    tc_exp = elapsed > {16'd0, tc_lim};
    tm_exp = map_rd.proto ? !has_conn_r[t_midx] : (elapsed > {16'd0, icmp_to_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nmt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (nmt_pkg::kind_t'(in_kind) == nmt_pkg::KIND_TICK) ?
                      nmt_pkg::S_TC_RD : nmt_pkg::S_MSCAN;
        end
      end
      nmt_pkg::S_MSCAN: begin
        if (ins_free || mscan_last) state_nxt = nmt_pkg::S_MDONE;
      end
      nmt_pkg::S_MDONE: begin
        if (!found_r)     state_nxt = nmt_pkg::S_IDLE;
        else if (proto_r) state_nxt = nmt_pkg::S_CSCAN;
        else              state_nxt = nmt_pkg::S_MWR;
      end
      nmt_pkg::S_CSCAN: begin
        if (c_match || cscan_last) state_nxt = nmt_pkg::S_CUPD;
      end
      nmt_pkg::S_CUPD: state_nxt = nmt_pkg::S_MWR;
      nmt_pkg::S_MWR:  state_nxt = nmt_pkg::S_IDLE;
      nmt_pkg::S_TC_RD: begin
        if (tc_end)                  state_nxt = nmt_pkg::S_TM_RD;
        else if (conn_vld_r[t_cidx]) state_nxt = nmt_pkg::S_TC_MAP;
      end
      nmt_pkg::S_TC_MAP: begin
        state_nxt = map_vld_r[conn_rd_owner] ? nmt_pkg::S_TC_DEC : nmt_pkg::S_TC_RD;
      end
      nmt_pkg::S_TC_DEC: state_nxt = nmt_pkg::S_TC_RD;
      nmt_pkg::S_TM_RD: begin
        if (tm_end)                state_nxt = nmt_pkg::S_IDLE;
        else if (map_vld_r[t_midx]) state_nxt = nmt_pkg::S_TM_DEC;
      end
      nmt_pkg::S_TM_DEC: state_nxt = nmt_pkg::S_TM_RD;
      default: state_nxt = nmt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    nmt_pkg::conn_data_t base, upd;
    logic [15:0] np;
    kind_nxt = kind_r;   proto_nxt = proto_r;
    iip_nxt = iip_r;     oip_nxt = oip_r;     dip_nxt = dip_r;
    iport_nxt = iport_r; oport_nxt = oport_r; dport_nxt = dport_r;
    flags_nxt = flags_r; seq_nxt = seq_r;     ack_nxt = ack_r;
    icmp_to_nxt = icmp_to_r; est_to_nxt = est_to_r;
    tra_to_nxt = tra_to_r;   minp_nxt = minp_r;
    next_tcp_nxt = next_tcp_r; next_icmp_nxt = next_icmp_r;
    now_nxt = now_r; icnt_nxt = icnt_r;
    map_vld_nxt = map_vld_r; has_conn_nxt = has_conn_r; conn_vld_nxt = conn_vld_r;
    rd_cnt_nxt = rd_cnt_r; pidx_nxt = pidx_r; t_idx_nxt = t_idx_r; pv_nxt = 1'b0;
    found_nxt = found_r; m_nxt = m_r; towner_nxt = towner_r; best_nxt = best_r;
    ment_nxt = ment_r; cfound_nxt = cfound_r; cfree_vld_nxt = cfree_vld_r;
    c_nxt = c_r; cfree_nxt = cfree_r; cent_nxt = cent_r; tphase_nxt = tphase_r;
    ov_nxt = 1'b0; ost_nxt = ost_r; oiip_nxt = oiip_r; ooip_nxt = ooip_r;
    oiport_nxt = oiport_r; ooport_nxt = ooport_r; ocs_nxt = ocs_r; odrop_nxt = odrop_r;
    map_we = 1'b0; map_waddr = m_r; map_wdata = MDW'(ment_r); map_raddr = '0;
    conn_we = 1'b0; conn_waddr = c_r; conn_wdata = '0; conn_raddr = '0;
    base = cent_r;
    upd  = cent_r;
    np   = 16'd0;

    if (cfg_we) begin
      unique case (nmt_pkg::reg_idx_t'(cfg_index))
        nmt_pkg::REG_ICMP_TO:  icmp_to_nxt = cfg_data;
        nmt_pkg::REG_EST_TO:   est_to_nxt  = cfg_data;
        nmt_pkg::REG_TRA_TO:   tra_to_nxt  = cfg_data;
        nmt_pkg::REG_MIN_PORT: minp_nxt    = cfg_data;
        default: begin
        end
      endcase
    end

    unique case (state_r)
      nmt_pkg::S_IDLE: begin
        if (start) begin
          kind_nxt = nmt_pkg::kind_t'(in_kind); proto_nxt = in_proto;
          iip_nxt = in_inner_ip;   iport_nxt = in_inner_port;
          oport_nxt = in_outer_port; oip_nxt = in_outer_ip;
          dip_nxt = in_dest_ip;    dport_nxt = in_dest_port;
          flags_nxt = in_segment_flags;
          seq_nxt = in_seq_number; ack_nxt = in_ack_number;
          rd_cnt_nxt = '0; t_idx_nxt = '0;
          found_nxt = 1'b0; best_nxt = '0;
          cfound_nxt = 1'b0; cfree_vld_nxt = 1'b0;
          ocs_nxt = nmt_pkg::PH_OPEN; odrop_nxt = 1'b0;
          oiip_nxt = '0; ooip_nxt = '0; oiport_nxt = '0; ooport_nxt = '0;
          if (nmt_pkg::kind_t'(in_kind) == nmt_pkg::KIND_TICK) begin
            now_nxt = now_r + 32'd1;
            has_conn_nxt = '0;
          end
        end
      end
      nmt_pkg::S_MSCAN: begin
        map_raddr = rd_cnt_r[MW-1:0];
        if (rd_cnt_r < SW'(MAP_ENTRIES)) begin
          pv_nxt = 1'b1;
          pidx_nxt = rd_cnt_r;
          rd_cnt_nxt = rd_cnt_r + SW'(1);
        end
        if (ins_free) begin
          found_nxt = 1'b1;
          m_nxt = mp_idx;
        end
        if (lk_hit && lk_better) begin
          found_nxt = 1'b1;
          m_nxt = mp_idx;
          best_nxt = lk_diff;
          ment_nxt = map_rd;
        end
      end
      nmt_pkg::S_MDONE: begin
        rd_cnt_nxt = '0;
        if (!found_r) begin
          ov_nxt = 1'b1;
          ost_nxt = (kind_r == nmt_pkg::KIND_INSERT) ? nmt_pkg::ST_FULL : nmt_pkg::ST_MISS;
        end else if (kind_r == nmt_pkg::KIND_INSERT) begin
          map_vld_nxt[m_r] = 1'b1;
          ment_nxt.proto = proto_r;
          ment_nxt.inner_ip = iip_r;
          ment_nxt.outer_ip = oip_r;
          ment_nxt.inner_port = iport_r;
          ment_nxt.stamp = icnt_r;
          icnt_nxt = icnt_r + 32'd1;
          if (proto_r) begin
            ment_nxt.outer_port = next_tcp_r;
            np = next_tcp_r + 16'd1;
            if (np < minp_r) np = np + minp_r;
            next_tcp_nxt = np;
          end else begin
            ment_nxt.outer_port = next_icmp_r;
            next_icmp_nxt = next_icmp_r + 16'd1;
          end
        end
      end
      nmt_pkg::S_CSCAN: begin
        conn_raddr = rd_cnt_r[CW-1:0];
        if (rd_cnt_r < SW'(CONN_ENTRIES)) begin
          pv_nxt = 1'b1;
          pidx_nxt = rd_cnt_r;
          rd_cnt_nxt = rd_cnt_r + SW'(1);
        end
        if (c_match) begin
          cfound_nxt = 1'b1;
          c_nxt = cp_idx;
          cent_nxt = conn_rd;
        end else if (pv_r && !conn_vld_r[cp_idx] && !cfree_vld_r) begin
          cfree_vld_nxt = 1'b1;
          cfree_nxt = cp_idx;
        end
      end
      nmt_pkg::S_CUPD: begin
        if (cfound_r || cfree_vld_r) begin
          if (cfound_r) begin
            base = cent_r;
          end else begin
            base = '0;
            base.dest_ip = dip_r;
            base.dest_port = dport_r;
          end
          upd = track(base, flags_r, seq_r, ack_r);
          conn_we = 1'b1;
          conn_waddr = cfound_r ? c_r : cfree_r;
          conn_wdata = {m_r, CDW'(upd)};
          conn_vld_nxt[conn_waddr] = 1'b1;
          ocs_nxt = upd.phase;
        end else begin
          odrop_nxt = 1'b1;
        end
      end
      nmt_pkg::S_MWR: begin
        map_we = 1'b1;
        map_wdata = MDW'({ment_r.proto, ment_r.inner_ip, ment_r.outer_ip,
                          ment_r.inner_port, ment_r.outer_port, now_r, ment_r.stamp});
        ov_nxt = 1'b1;
        ost_nxt = (kind_r == nmt_pkg::KIND_INSERT) ? nmt_pkg::ST_INSERTED : nmt_pkg::ST_HIT;
        oiip_nxt = ment_r.inner_ip;
        ooip_nxt = ment_r.outer_ip;
        oiport_nxt = ment_r.inner_port;
        ooport_nxt = ment_r.outer_port;
      end
      nmt_pkg::S_TC_RD: begin
        conn_raddr = t_cidx;
        if (tc_end) begin
          t_idx_nxt = '0;
        end else if (!conn_vld_r[t_cidx]) begin
          t_idx_nxt = t_idx_r + SW'(1);
        end
      end
      nmt_pkg::S_TC_MAP: begin
        map_raddr = conn_rd_owner;
        towner_nxt = conn_rd_owner;
        tphase_nxt = conn_rd.phase;
        if (!map_vld_r[conn_rd_owner]) begin
          conn_vld_nxt[t_cidx] = 1'b0;
          t_idx_nxt = t_idx_r + SW'(1);
        end
      end
      nmt_pkg::S_TC_DEC: begin
        if (tc_exp) conn_vld_nxt[t_cidx] = 1'b0;
        else        has_conn_nxt[towner_r] = 1'b1;
        t_idx_nxt = t_idx_r + SW'(1);
      end
      nmt_pkg::S_TM_RD: begin
        map_raddr = t_midx;
        if (tm_end) begin
          ov_nxt = 1'b1;
          ost_nxt = nmt_pkg::ST_TICK_DONE;
        end else if (!map_vld_r[t_midx]) begin
          t_idx_nxt = t_idx_r + SW'(1);
        end
      end
      nmt_pkg::S_TM_DEC: begin
        if (tm_exp) map_vld_nxt[t_midx] = 1'b0;
        t_idx_nxt = t_idx_r + SW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nmt_pkg::S_IDLE;
      icmp_to_r   <= 16'd60;
      est_to_r    <= 16'd7440;
      tra_to_r    <= 16'd300;
      minp_r      <= 16'd1024;
      next_tcp_r  <= 16'd1024;
      next_icmp_r <= 16'd1;
      now_r       <= '0;
      icnt_r      <= '0;
      map_vld_r   <= '0;
      has_conn_r  <= '0;
      conn_vld_r  <= '0;
      pv_r        <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      icmp_to_r   <= icmp_to_nxt;
      est_to_r    <= est_to_nxt;
      tra_to_r    <= tra_to_nxt;
      minp_r      <= minp_nxt;
      next_tcp_r  <= next_tcp_nxt;
      next_icmp_r <= next_icmp_nxt;
      now_r       <= now_nxt;
      icnt_r      <= icnt_nxt;
      map_vld_r   <= map_vld_nxt;
      has_conn_r  <= has_conn_nxt;
      conn_vld_r  <= conn_vld_nxt;
      pv_r        <= pv_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;   proto_r <= proto_nxt;
    iip_r <= iip_nxt;     oip_r <= oip_nxt;     dip_r <= dip_nxt;
    iport_r <= iport_nxt; oport_r <= oport_nxt; dport_r <= dport_nxt;
    flags_r <= flags_nxt; seq_r <= seq_nxt;     ack_r <= ack_nxt;
    rd_cnt_r <= rd_cnt_nxt; pidx_r <= pidx_nxt; t_idx_r <= t_idx_nxt;
    found_r <= found_nxt; m_r <= m_nxt; towner_r <= towner_nxt; best_r <= best_nxt;
    ment_r <= ment_nxt; cfound_r <= cfound_nxt; cfree_vld_r <= cfree_vld_nxt;
    c_r <= c_nxt; cfree_r <= cfree_nxt; cent_r <= cent_nxt; tphase_r <= tphase_nxt;
    ost_r <= ost_nxt; oiip_r <= oiip_nxt; ooip_r <= ooip_nxt;
    oiport_r <= oiport_nxt; ooport_r <= ooport_nxt;
    ocs_r <= ocs_nxt; odrop_r <= odrop_nxt;
  end

  assign busy                 = (state_r != nmt_pkg::S_IDLE);
  assign out_valid            = ov_r;
  assign out_status           = ost_r;
  assign out_found_inner_ip   = oiip_r;
  assign out_found_outer_ip   = ooip_r;
  assign out_found_inner_port = oiport_r;
  assign out_found_outer_port = ooport_r;
  assign out_conn_state       = ocs_r;
  assign out_conn_dropped     = odrop_r;

endmodule
